// ----- rtl/core/hfps_pkg.sv -----
// ============================================================================
// hfps_pkg
// Shared constants, types and constant tables for the Hann-window FFT
// power spectrum core: frame size, data widths, datapath command codes and
// the Q1.15 window and twiddle tables built at elaboration.
// ============================================================================
package hfps_pkg;

    // Frame geometry
    localparam int C_FFT_POINTS = 128;
    localparam int C_LOG2N      = $clog2(C_FFT_POINTS);
    localparam int C_ADDR_W     = C_LOG2N;
    localparam int C_BFLY_W     = C_LOG2N - 1;
    localparam int C_STAGE_W    = $clog2(C_LOG2N);
    localparam int C_TW_DEPTH   = C_FFT_POINTS / 2;

    // Data widths
    localparam int C_DATA_W     = 32;
    localparam int C_COEF_W     = 16;
    localparam int C_PROD_W     = C_DATA_W + C_COEF_W;
    localparam int C_SUM_W      = C_PROD_W + 1;
    localparam int C_SQ_W       = 2 * C_DATA_W;
    localparam int C_POW_W      = 48;
    localparam int C_CFG_W      = 8;
    localparam int C_BIN_W      = 6;
    localparam int C_SAMPLE_W   = 8;

    // Result count limit: half the frame, at most 64 bins
    localparam int C_MAX_OUT    = (C_FFT_POINTS / 2 < 64) ? C_FFT_POINTS / 2 : 64;
    localparam int C_CNT_W      = $clog2(C_MAX_OUT + 1);

    localparam logic [C_POW_W-1:0] C_POWER_MAX = {C_POW_W{1'b1}};
    localparam logic [63:0]        C_TWO_PI_Q30 = 64'd6746518852;

    // Datapath command codes
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_RD_E,
        OP_RD_O,
        OP_MUL,
        OP_ADD,
        OP_WR_E,
        OP_WR_O,
        OP_PW_RD,
        OP_PW_MUL,
        OP_PW_SUM
    } t_dp_op;

    typedef struct packed {
        t_dp_op                op;
        logic [C_ADDR_W-1:0]   load_idx;
        logic [C_STAGE_W-1:0]  stage;
        logic [C_BFLY_W-1:0]   bfly;
        logic [C_BIN_W-1:0]    bin;
        logic                  last;
    } t_dp_cmd;

    typedef struct packed {
        longint c;
        longint s;
    } t_sincos;

    typedef logic signed [C_COEF_W-1:0] t_win_tab [0:C_FFT_POINTS-1];
    typedef logic signed [C_COEF_W-1:0] t_tw_tab  [0:C_TW_DEPTH-1];

    // Q30 cosine and sine of ph / 2^32 turns, octant reduced Taylor series
    function automatic t_sincos f_sincos(input logic [31:0] ph);
        logic [1:0]  quad;
        logic [31:0] f;
        logic        swap;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        longint      cv;
        longint      sv;
        longint      c0;
        longint      s0;
        t_sincos     r;
        quad = ph[31:30];
        f    = {2'b00, ph[29:0]};
        swap = f > 32'h2000_0000;
        if (swap) begin
            f = 32'h4000_0000 - f;
        end
        x  = ({32'd0, f} * C_TWO_PI_Q30) >> 32;
        x2 = (x * x) >> 30;
        // cosine terms
        t  = 64'd1 << 30;
        cv = $signed(t);
        t = ((t * x2) >> 30) / 64'd2;   cv = cv - $signed(t);
        t = ((t * x2) >> 30) / 64'd12;  cv = cv + $signed(t);
        t = ((t * x2) >> 30) / 64'd30;  cv = cv - $signed(t);
        t = ((t * x2) >> 30) / 64'd56;  cv = cv + $signed(t);
        t = ((t * x2) >> 30) / 64'd90;  cv = cv - $signed(t);
        t = ((t * x2) >> 30) / 64'd132; cv = cv + $signed(t);
        // sine terms
        t  = x;
        sv = $signed(t);
        t = ((t * x2) >> 30) / 64'd6;   sv = sv - $signed(t);
        t = ((t * x2) >> 30) / 64'd20;  sv = sv + $signed(t);
        t = ((t * x2) >> 30) / 64'd42;  sv = sv - $signed(t);
        t = ((t * x2) >> 30) / 64'd72;  sv = sv + $signed(t);
        t = ((t * x2) >> 30) / 64'd110; sv = sv - $signed(t);
        t = ((t * x2) >> 30) / 64'd156; sv = sv + $signed(t);
        if (swap) begin
            c0 = sv;
            s0 = cv;
        end else begin
            c0 = cv;
            s0 = sv;
        end
        unique case (quad)
            2'd0: begin r.c = c0;  r.s = s0;  end
            2'd1: begin r.c = -s0; r.s = c0;  end
            2'd2: begin r.c = -c0; r.s = -s0; end
            default: begin r.c = s0; r.s = -c0; end
        endcase
        return r;
    endfunction

    // Round half up from Q30 to Q15 with saturation
    function automatic logic signed [C_COEF_W-1:0] f_q30_to_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        if (r < -64'sd32768) begin
            r = -64'sd32768;
        end
        return C_COEF_W'(r);
    endfunction

    function automatic t_win_tab f_build_win();
        t_win_tab    tab;
        logic [63:0] num;
        logic [31:0] ph;
        t_sincos     sc;
        for (int i = 0; i < C_FFT_POINTS; i++) begin
            num    = {32'(i), 32'd0};
            ph     = 32'(num / (C_FFT_POINTS - 1));
            sc     = f_sincos(ph);
            tab[i] = f_q30_to_q15(((64'sd1 <<< 30) - sc.c) / 2);
        end
        return tab;
    endfunction

    function automatic t_tw_tab f_build_cos();
        t_tw_tab tab;
        t_sincos sc;
        for (int i = 0; i < C_TW_DEPTH; i++) begin
            sc     = f_sincos(32'(i) << (32 - C_LOG2N));
            tab[i] = f_q30_to_q15(sc.c);
        end
        return tab;
    endfunction

    function automatic t_tw_tab f_build_nsin();
        t_tw_tab tab;
        t_sincos sc;
        for (int i = 0; i < C_TW_DEPTH; i++) begin
            sc     = f_sincos(32'(i) << (32 - C_LOG2N));
            tab[i] = f_q30_to_q15(-sc.s);
        end
        return tab;
    endfunction

    localparam t_win_tab C_WIN_TAB  = f_build_win();
    localparam t_tw_tab  C_TW_COS   = f_build_cos();
    localparam t_tw_tab  C_TW_NSIN  = f_build_nsin();

endpackage

// ----- rtl/core/hfps_ram.sv -----
// ============================================================================
// hfps_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module hfps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/hfps_datapath.sv -----
// ============================================================================
// hfps_datapath
// Sample windowing, frame store, shared radix-2 butterfly and power unit.
// Every action is selected by the command from the controller.
// ============================================================================
module hfps_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hfps_pkg::t_dp_cmd               i_cmd,
    input  logic [hfps_pkg::C_SAMPLE_W-1:0] i_sample_byte,
    output logic                            o_result_valid,
    output logic [hfps_pkg::C_POW_W-1:0]    o_bin_power,
    output logic [hfps_pkg::C_BIN_W-1:0]    o_bin_index,
    output logic                            o_last_bin
);

    localparam int AW = hfps_pkg::C_ADDR_W;
    localparam int DW = hfps_pkg::C_DATA_W;

    logic [AW-1:0]   bfly_ext;
    logic [AW-1:0]   mask;
    logic [AW-1:0]   j_idx;
    logic [AW-1:0]   e_addr;
    logic [AW-1:0]   o_addr;
    logic [AW-1:0]   k_full;
    logic [AW-2:0]   k_idx;
    logic [AW-1:0]   rev_addr;
    logic signed [hfps_pkg::C_COEF_W-1:0] tw_re;
    logic signed [hfps_pkg::C_COEF_W-1:0] tw_im;
    logic signed [hfps_pkg::C_COEF_W-1:0] win;
    logic signed [9:0]  centered;
    logic signed [17:0] samp_q16;
    logic signed [33:0] win_prod;
    logic signed [33:0] win_rnd;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    logic [2*DW-1:0] wdata;
    logic [2*DW-1:0] rdata;
    logic signed [DW-1:0] rd_re;
    logic signed [DW-1:0] rd_im;

    logic signed [DW-1:0] r_xe_re;
    logic signed [DW-1:0] r_xe_im;
    logic signed [hfps_pkg::C_PROD_W-1:0] r_p_rr;
    logic signed [hfps_pkg::C_PROD_W-1:0] r_p_ii;
    logic signed [hfps_pkg::C_PROD_W-1:0] r_p_ri;
    logic signed [hfps_pkg::C_PROD_W-1:0] r_p_ir;
    logic signed [hfps_pkg::C_SUM_W-1:0]  sum_re;
    logic signed [hfps_pkg::C_SUM_W-1:0]  sum_im;
    logic signed [DW-1:0] r_t_re;
    logic signed [DW-1:0] r_t_im;
    logic signed [hfps_pkg::C_SQ_W-1:0]   r_sq_re;
    logic signed [hfps_pkg::C_SQ_W-1:0]   r_sq_im;
    logic [hfps_pkg::C_SQ_W:0]            pw_sum;
    logic [hfps_pkg::C_POW_W-1:0]         pw_sat;

    logic                           r_valid;
    logic [hfps_pkg::C_POW_W-1:0]   r_power;
    logic [hfps_pkg::C_BIN_W-1:0]   r_index;
    logic                           r_last;

    // butterfly addressing: even/odd leg and twiddle index for this stage
    always_comb begin
        bfly_ext = {1'b0, i_cmd.bfly};
        mask     = AW'((1 << i_cmd.stage) - 1);
        j_idx    = bfly_ext & mask;
        e_addr   = ((bfly_ext >> i_cmd.stage) << (i_cmd.stage + 1)) | j_idx;
        o_addr   = e_addr | AW'(1 << i_cmd.stage);
        k_full   = j_idx << (AW - 1 - i_cmd.stage);
        k_idx    = k_full[AW-2:0];
    end

    // bit-reversed load address puts the frame in FFT input order
    always_comb begin
        for (int b = 0; b < AW; b++) begin
            rev_addr[b] = i_cmd.load_idx[AW-1-b];
        end
    end

    assign tw_re = hfps_pkg::C_TW_COS[k_idx];
    assign tw_im = hfps_pkg::C_TW_NSIN[k_idx];
    assign win   = hfps_pkg::C_WIN_TAB[i_cmd.load_idx];

    // center, scale and window the incoming sample
    always_comb begin
        centered = $signed({1'b0, i_sample_byte, 1'b0}) - 10'sd255;
        samp_q16 = {centered, 8'd0};
        win_prod = 34'(samp_q16) * 34'(win);
        win_rnd  = (win_prod + 34'sd16384) >>> 15;
    end

    assign rd_re = rdata[2*DW-1:DW];
    assign rd_im = rdata[DW-1:0];

    // frame store port selection
    always_comb begin
        we    = 1'b0;
        waddr = e_addr;
        wdata = {r_xe_re + r_t_re, r_xe_im + r_t_im};
        raddr = e_addr;
        unique case (i_cmd.op)
            hfps_pkg::OP_LOAD: begin
                we    = 1'b1;
                waddr = rev_addr;
                wdata = {DW'(win_rnd), {DW{1'b0}}};
            end
            hfps_pkg::OP_WR_E: begin
                we = 1'b1;
            end
            hfps_pkg::OP_WR_O: begin
                we    = 1'b1;
                waddr = o_addr;
                wdata = {r_xe_re - r_t_re, r_xe_im - r_t_im};
            end
            hfps_pkg::OP_RD_O: begin
                raddr = o_addr;
            end
            hfps_pkg::OP_PW_RD: begin
                raddr = AW'(i_cmd.bin);
            end
            default: begin
            end
        endcase
    end

    hfps_ram #(
        .WIDTH (2 * DW),
        .DEPTH (hfps_pkg::C_FFT_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // twiddle sums before rounding
    always_comb begin
        sum_re = hfps_pkg::C_SUM_W'(r_p_rr) - hfps_pkg::C_SUM_W'(r_p_ii);
        sum_im = hfps_pkg::C_SUM_W'(r_p_ri) + hfps_pkg::C_SUM_W'(r_p_ir);
    end

    // power with saturation
    always_comb begin
        pw_sum = {1'b0, r_sq_re} + {1'b0, r_sq_im};
        if (pw_sum > (hfps_pkg::C_SQ_W+1)'(hfps_pkg::C_POWER_MAX)) begin
            pw_sat = hfps_pkg::C_POWER_MAX;
        end else begin
            pw_sat = pw_sum[hfps_pkg::C_POW_W-1:0];
        end
    end

    // butterfly and power pipeline registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            hfps_pkg::OP_RD_O: begin
                r_xe_re <= rd_re;
                r_xe_im <= rd_im;
            end
            hfps_pkg::OP_MUL: begin
                r_p_rr <= hfps_pkg::C_PROD_W'(tw_re) * hfps_pkg::C_PROD_W'(rd_re);
                r_p_ii <= hfps_pkg::C_PROD_W'(tw_im) * hfps_pkg::C_PROD_W'(rd_im);
                r_p_ri <= hfps_pkg::C_PROD_W'(tw_re) * hfps_pkg::C_PROD_W'(rd_im);
                r_p_ir <= hfps_pkg::C_PROD_W'(tw_im) * hfps_pkg::C_PROD_W'(rd_re);
            end
            hfps_pkg::OP_ADD: begin
                r_t_re <= DW'((sum_re + hfps_pkg::C_SUM_W'(16384)) >>> 15);
                r_t_im <= DW'((sum_im + hfps_pkg::C_SUM_W'(16384)) >>> 15);
            end
            hfps_pkg::OP_PW_MUL: begin
                r_sq_re <= hfps_pkg::C_SQ_W'(rd_re) * hfps_pkg::C_SQ_W'(rd_re);
                r_sq_im <= hfps_pkg::C_SQ_W'(rd_im) * hfps_pkg::C_SQ_W'(rd_im);
            end
            hfps_pkg::OP_PW_SUM: begin
                r_power <= pw_sat;
                r_index <= i_cmd.bin;
                r_last  <= i_cmd.last;
            end
            default: begin
            end
        endcase
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == hfps_pkg::OP_PW_SUM);
        end
    end

    assign o_result_valid = r_valid;
    assign o_bin_power    = r_power;
    assign o_bin_index    = r_index;
    assign o_last_bin     = r_last;

    // odd leg sits exactly one half-span above the even leg
    a_leg_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == hfps_pkg::OP_RD_O) |-> ((o_addr - e_addr) == AW'(1 << i_cmd.stage)))
        else $error("butterfly legs misaligned");

    // a power sum command must be preceded by a power read command
    a_pw_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == hfps_pkg::OP_PW_SUM) |-> ($past(i_cmd.op, 2) == hfps_pkg::OP_PW_RD))
        else $error("power sum without read");

endmodule

// ----- rtl/core/hfps_ctrl.sv -----
// ============================================================================
// hfps_ctrl
// Frame sequencer: sample load count, FFT stage and butterfly counters,
// bin readout counter and the bin count register.
// ============================================================================
module hfps_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_cfg_we,
    input  logic [hfps_pkg::C_CFG_W-1:0] i_cfg_wdata,
    output logic                         o_busy,
    output hfps_pkg::t_dp_cmd            o_cmd
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_RD_E,
        S_RD_O,
        S_MUL,
        S_ADD,
        S_WR_E,
        S_WR_O,
        S_PW_RD,
        S_PW_MUL,
        S_PW_SUM
    } t_state;

    t_state                            r_state;
    logic                              r_busy;
    logic [hfps_pkg::C_CFG_W-1:0]      r_bins;
    logic [hfps_pkg::C_ADDR_W-1:0]     r_load_cnt;
    logic [hfps_pkg::C_STAGE_W-1:0]    r_stage;
    logic [hfps_pkg::C_BFLY_W-1:0]     r_bfly;
    logic [hfps_pkg::C_BIN_W-1:0]      r_bin;
    logic [hfps_pkg::C_BIN_W-1:0]      r_bin_last;

    logic [hfps_pkg::C_CFG_W-1:0]      half_req;
    logic [hfps_pkg::C_CNT_W-1:0]      n_count;

    // number of bins to report for this frame
    always_comb begin
        half_req = r_bins >> 1;
        if (half_req > hfps_pkg::C_CFG_W'(hfps_pkg::C_MAX_OUT)) begin
            n_count = hfps_pkg::C_CNT_W'(hfps_pkg::C_MAX_OUT);
        end else begin
            n_count = hfps_pkg::C_CNT_W'(half_req);
        end
    end

    // bin count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins <= hfps_pkg::C_CFG_W'(128);
        end else if (i_cfg_we) begin
            r_bins <= i_cfg_wdata;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_busy     <= 1'b0;
            r_load_cnt <= '0;
            r_stage    <= '0;
            r_bfly     <= '0;
            r_bin      <= '0;
            r_bin_last <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (i_start) begin
                        r_load_cnt <= r_load_cnt + 1'b1;
                        if (r_load_cnt == hfps_pkg::C_ADDR_W'(hfps_pkg::C_FFT_POINTS - 1)) begin
                            r_stage <= '0;
                            r_bfly  <= '0;
                            r_busy  <= 1'b1;
                            r_state <= S_RD_E;
                        end
                    end
                end
                S_RD_E:  r_state <= S_RD_O;
                S_RD_O:  r_state <= S_MUL;
                S_MUL:   r_state <= S_ADD;
                S_ADD:   r_state <= S_WR_E;
                S_WR_E:  r_state <= S_WR_O;
                S_WR_O: begin
                    r_bfly  <= r_bfly + 1'b1;
                    r_state <= S_RD_E;
                    if (r_bfly == {hfps_pkg::C_BFLY_W{1'b1}}) begin
                        r_stage <= r_stage + 1'b1;
                        if (r_stage == hfps_pkg::C_STAGE_W'(hfps_pkg::C_LOG2N - 1)) begin
                            // transform done: read out or go back to loading
                            r_bin      <= '0;
                            r_bin_last <= hfps_pkg::C_BIN_W'(n_count - 1'b1);
                            if (n_count == '0) begin
                                r_busy  <= 1'b0;
                                r_state <= S_LOAD;
                            end else begin
                                r_state <= S_PW_RD;
                            end
                        end
                    end
                end
                S_PW_RD:  r_state <= S_PW_MUL;
                S_PW_MUL: r_state <= S_PW_SUM;
                S_PW_SUM: begin
                    if (r_bin == r_bin_last) begin
                        r_busy  <= 1'b0;
                        r_state <= S_LOAD;
                    end else begin
                        r_bin   <= r_bin + 1'b1;
                        r_state <= S_PW_RD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // command to the datapath
    always_comb begin
        o_cmd.load_idx = r_load_cnt;
        o_cmd.stage    = r_stage;
        o_cmd.bfly     = r_bfly;
        o_cmd.bin      = r_bin;
        o_cmd.last     = (r_bin == r_bin_last);
        unique case (r_state)
            S_LOAD:   o_cmd.op = i_start ? hfps_pkg::OP_LOAD : hfps_pkg::OP_IDLE;
            S_RD_E:   o_cmd.op = hfps_pkg::OP_RD_E;
            S_RD_O:   o_cmd.op = hfps_pkg::OP_RD_O;
            S_MUL:    o_cmd.op = hfps_pkg::OP_MUL;
            S_ADD:    o_cmd.op = hfps_pkg::OP_ADD;
            S_WR_E:   o_cmd.op = hfps_pkg::OP_WR_E;
            S_WR_O:   o_cmd.op = hfps_pkg::OP_WR_O;
            S_PW_RD:  o_cmd.op = hfps_pkg::OP_PW_RD;
            S_PW_MUL: o_cmd.op = hfps_pkg::OP_PW_MUL;
            S_PW_SUM: o_cmd.op = hfps_pkg::OP_PW_SUM;
            default:  o_cmd.op = hfps_pkg::OP_IDLE;
        endcase
    end

    assign o_busy = r_busy;

    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_LOAD))
        else $error("busy flag out of step with state");

    a_frame_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> ($past(r_load_cnt) ==
            hfps_pkg::C_ADDR_W'(hfps_pkg::C_FFT_POINTS - 1)) && (r_load_cnt == '0))
        else $error("transform started on a partial frame");

    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PW_RD) |-> (r_bin <= r_bin_last))
        else $error("bin counter past last bin");

endmodule

// ----- rtl/core/hann_fft_power_spectrum_core.sv -----
// ============================================================================
// hann_fft_power_spectrum_core
// Hann-windowed 128-point radix-2 FFT power spectrum of 8-bit samples.
// ============================================================================
// Usage:
//   Input: drive i_sample_byte and raise start; a sample item is taken on a
//   clock edge where start is high and busy is low. Samples load one per
//   cycle; the 128th sample starts the transform and raises busy.
//   Transform: one shared butterfly reads the even and odd legs, multiplies
//   by the twiddle, adds and writes both legs back over the frame store's
//   single read and single write port.
//   Readout: each bin is read, squared and summed before the next bin is
//   read; o_result_valid is high for one cycle per item with o_bin_power,
//   o_bin_index and o_last_bin. floor(min(bins,128)/2) bins, at most 64,
//   are reported; 0 bins when fewer than 2 are requested.
//   The edge that raises the strobe of the last bin also drops busy, so the
//   next frame may load in that cycle.
//   Configuration: i_cfg_we / i_cfg_wdata write the bin count; reset value
//   128. Write only while busy is low and no results are pending.
//   Reset (synchronous, active low) clears the load count and sequencer.
//   The receiver cannot stall: each result is valid for exactly one cycle.
// ============================================================================
module hann_fft_power_spectrum_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [hfps_pkg::C_SAMPLE_W-1:0] i_sample_byte,
    input  logic                            i_cfg_we,
    input  logic [hfps_pkg::C_CFG_W-1:0]    i_cfg_wdata,
    output logic                            o_result_valid,
    output logic [hfps_pkg::C_POW_W-1:0]    o_bin_power,
    output logic [hfps_pkg::C_BIN_W-1:0]    o_bin_index,
    output logic                            o_last_bin
);

    hfps_pkg::t_dp_cmd cmd;
    logic              ctrl_busy;
    logic              start_ok;

    // accept sample items only while idle
    assign start_ok = start & ~ctrl_busy;

    hfps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start_ok),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_busy      (ctrl_busy),
        .o_cmd       (cmd)
    );

    hfps_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_sample_byte  (i_sample_byte),
        .o_result_valid (o_result_valid),
        .o_bin_power    (o_bin_power),
        .o_bin_index    (o_bin_index),
        .o_last_bin     (o_last_bin)
    );

    assign busy = ctrl_busy;

endmodule
